// ===== hw/rtl/reflow_profile_sequencer_macros.svh =====
// assertion macros for the reflow profile sequencer checker
// expects clk and arst_n in the scope where a macro is used
`ifndef REFLOW_PROFILE_SEQUENCER_MACROS_SVH
`define REFLOW_PROFILE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define RPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("reflow sequencer check failed");

// next-cycle implication
`define RPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("reflow sequencer check failed");

`endif

// ===== hw/rtl/rps_pkg.sv =====
// types, codes and profile lookups shared by the reflow profile sequencer
// no dependencies
package rps_pkg;

	localparam int TIME_W    = 10;
	localparam int TEMP_W    = 9;
	localparam int REG_STEPS = 6;
	localparam int TIMES_W   = TIME_W * REG_STEPS;
	localparam int TEMPS_W   = TEMP_W * REG_STEPS;
	localparam int WIN_W     = 12;
	localparam int MS_W      = 20;
	localparam int MSEC_W    = 10;
	localparam int SEC_W     = 11;
	localparam int STEP_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = TIMES_W;

	localparam logic [MS_W-1:0]   MS_MAX      = '1;
	localparam logic [SEC_W-1:0]  SEC_MAX     = '1;
	localparam logic [MSEC_W-1:0] MSEC_LAST   = MSEC_W'(999);
	localparam logic [WIN_W-1:0]  WINDOW_RST  = WIN_W'(2000);
	localparam logic [TEMP_W-1:0] PREHEAT_T_RST = TEMP_W'(80);
	localparam logic [MS_W-1:0]   PREHEAT_D_RST = MS_W'(4 * 60 * 1000);

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_PREHEAT = 2'd1,
		MODE_REFLOW  = 2'd2,
		MODE_STOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_REFLOW  = 2'd1,
		PH_PREHEAT = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH    = 3'd0,
		REG_PROFILE_TIMES    = 3'd1,
		REG_PROFILE_TEMPS    = 3'd2,
		REG_PREHEAT_TEMP     = 3'd3,
		REG_PREHEAT_DURATION = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [WIN_W-1:0]   window_length;
		logic [TIMES_W-1:0] profile_times;
		logic [TEMPS_W-1:0] profile_temps;
		logic [TEMP_W-1:0]  preheat_temp;
		logic [MS_W-1:0]    preheat_duration;
	} rps_cfg_t;

	// steps past the packed fields read as zero
	function automatic logic [TIME_W-1:0] step_time(input logic [TIMES_W-1:0] times,
			input logic [STEP_W-1:0] s);
		logic [TIME_W-1:0] t;
		t = '0;
		if (int'(s) < REG_STEPS) begin
			t = times[int'(s) * TIME_W +: TIME_W];
		end
		return t;
	endfunction

	function automatic logic [TEMP_W-1:0] step_temp(input logic [TEMPS_W-1:0] temps,
			input logic [STEP_W-1:0] s);
		logic [TEMP_W-1:0] t;
		t = '0;
		if (int'(s) < REG_STEPS) begin
			t = temps[int'(s) * TEMP_W +: TEMP_W];
		end
		return t;
	endfunction

endpackage

// ===== hw/rtl/rps_cmd_if.sv =====
// command/tick channel of the reflow profile sequencer
// depends on rps_pkg for field widths
interface rps_cmd_if;
	import rps_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [WIN_W-1:0]  drive;

	modport source (output valid, output mode, output drive, input ready);
	modport sink (input valid, input mode, input drive, output ready);
endinterface

// ===== hw/rtl/rps_result_if.sv =====
// result channel of the reflow profile sequencer
// depends on rps_pkg for field widths
interface rps_result_if;
	import rps_pkg::*;

	logic              valid;
	logic              ready;
	logic              relay_on;
	logic [TEMP_W-1:0] setpoint;
	logic [1:0]        phase;
	logic [STEP_W-1:0] step_index;
	logic              finished;

	modport source (output valid, output relay_on, output setpoint, output phase,
		output step_index, output finished, input ready);
	modport sink (input valid, input relay_on, input setpoint, input phase,
		input step_index, input finished, output ready);
endinterface

// ===== hw/rtl/rps_cfg_if.sv =====
// configuration write channel of the reflow profile sequencer
// depends on rps_pkg for index and data widths
interface rps_cfg_if;
	import rps_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/reflow_profile_sequencer.sv =====
// reflow oven sequencer: phase control, run timers, relay window and result register
// depends on rps_pkg, the three channel interfaces and rps_cfg_regs
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------
//  cmd      | in  | mode, drive
//  result   | out | relay_on, setpoint, phase, step_index, finished
//  cfg      | in  | index, data (register writes, always ready)
//
// one item per cycle unless stalled; a result is offered the cycle after acceptance
// the result register frees cmd.ready whenever it is empty or being taken
// a stalled result holds, and cmd is accepted again as soon as it drains
// arst_n clears the run state and loads the register reset values; no clearing pass
module reflow_profile_sequencer #(
	parameter int PROFILE_STEPS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	rps_cmd_if.sink    cmd,
	rps_result_if.source result,
	rps_cfg_if.sink    cfg
);
	import rps_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROFILE_STEPS - 1);

	rps_cfg_t regs;

	rps_cfg_regs u_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.regs  (regs)
	);

	// run state
	phase_t             phase_q;
	logic [MS_W-1:0]    ms_q;
	logic [MSEC_W-1:0]  msec_q;
	logic [SEC_W-1:0]   sec_q;
	logic [WIN_W-1:0]   win_q;
	logic [STEP_W-1:0]  step_q;

	// result register
	logic               res_valid_q;
	logic               relay_on_q;
	logic [TEMP_W-1:0]  setpoint_q;
	logic [1:0]         phase_out_q;
	logic [STEP_W-1:0]  step_index_q;
	logic               finished_q;

	phase_t             phase_n;
	logic [MS_W-1:0]    ms_n;
	logic [MSEC_W-1:0]  msec_n;
	logic [SEC_W-1:0]   sec_n;
	logic [WIN_W-1:0]   win_n;
	logic [STEP_W-1:0]  step_n;
	logic               fin_n;
	logic [WIN_W:0]     win_inc;
	logic [TIME_W-1:0]  cur_time;
	logic               running_n;
	logic               relay_n;
	logic [TEMP_W-1:0]  setpoint_n;
	logic [STEP_W-1:0]  step_out_n;
	logic               cmd_fire;

	assign cmd.ready = !res_valid_q || result.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign win_inc   = {1'b0, win_q} + (WIN_W+1)'(1);
	assign cur_time  = step_time(regs.profile_times, step_q);

	always_comb begin
		phase_n = phase_q;
		ms_n    = ms_q;
		msec_n  = msec_q;
		sec_n   = sec_q;
		win_n   = win_q;
		step_n  = step_q;
		fin_n   = 1'b0;
		case (mode_t'(cmd.mode))
			MODE_PREHEAT, MODE_REFLOW, MODE_STOP: begin
				phase_n = (mode_t'(cmd.mode) == MODE_PREHEAT) ? PH_PREHEAT :
				          (mode_t'(cmd.mode) == MODE_REFLOW) ? PH_REFLOW : PH_IDLE;
				ms_n    = '0;
				msec_n  = '0;
				sec_n   = '0;
				win_n   = '0;
				step_n  = '0;
			end
			default: begin
				case (phase_q)
					PH_IDLE: begin
						step_n = '0;
					end
					PH_PREHEAT, PH_REFLOW: begin
						ms_n = (ms_q != MS_MAX) ? ms_q + MS_W'(1) : ms_q;
						if (msec_q >= MSEC_LAST) begin
							msec_n = '0;
							sec_n  = (sec_q != SEC_MAX) ? sec_q + SEC_W'(1) : sec_q;
						end else begin
							msec_n = msec_q + MSEC_W'(1);
						end
						// window wraps at its length, also after the length shrank
						win_n = (win_inc >= {1'b0, regs.window_length}) ? '0 : win_inc[WIN_W-1:0];
						if (phase_q == PH_PREHEAT) begin
							if (ms_n > regs.preheat_duration) begin
								phase_n = PH_IDLE;
								step_n  = '0;
								fin_n   = 1'b1;
							end
						end else if (sec_n > {1'b0, cur_time}) begin
							if (step_q >= LAST_STEP) begin
								phase_n = PH_IDLE;
								step_n  = '0;
								fin_n   = 1'b1;
							end else begin
								step_n = step_q + STEP_W'(1);
							end
						end
					end
					default: begin
						phase_n = PH_IDLE;
						step_n  = '0;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		running_n  = (phase_n == PH_PREHEAT) || (phase_n == PH_REFLOW);
		relay_n    = running_n && (cmd.drive >= win_n);
		setpoint_n = '0;
		step_out_n = '0;
		case (phase_n)
			PH_PREHEAT: setpoint_n = regs.preheat_temp;
			PH_REFLOW: begin
				setpoint_n = step_temp(regs.profile_temps, step_n);
				step_out_n = step_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ms_q    <= '0;
			msec_q  <= '0;
			sec_q   <= '0;
			win_q   <= '0;
			step_q  <= '0;
		end else if (cmd_fire) begin
			phase_q <= phase_n;
			ms_q    <= ms_n;
			msec_q  <= msec_n;
			sec_q   <= sec_n;
			win_q   <= win_n;
			step_q  <= step_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			relay_on_q   <= relay_n;
			setpoint_q   <= setpoint_n;
			phase_out_q  <= phase_n;
			step_index_q <= step_out_n;
			finished_q   <= fin_n;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.relay_on   = relay_on_q;
	assign result.setpoint   = setpoint_q;
	assign result.phase      = phase_out_q;
	assign result.step_index = step_index_q;
	assign result.finished   = finished_q;

endmodule

// ===== hw/rtl/rps_cfg_regs.sv =====
// configuration register file: decodes writes and holds the five settings
// depends on rps_pkg and rps_cfg_if
module rps_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	rps_cfg_if.sink        cfg,
	output rps_pkg::rps_cfg_t regs
);
	import rps_pkg::*;

	rps_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.window_length    <= WINDOW_RST;
			regs_q.profile_times    <= '0;
			regs_q.profile_temps    <= '0;
			regs_q.preheat_temp     <= PREHEAT_T_RST;
			regs_q.preheat_duration <= PREHEAT_D_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_idx_t'(cfg.index))
				REG_WINDOW_LENGTH:    regs_q.window_length    <= cfg.data[WIN_W-1:0];
				REG_PROFILE_TIMES:    regs_q.profile_times    <= cfg.data[TIMES_W-1:0];
				REG_PROFILE_TEMPS:    regs_q.profile_temps    <= cfg.data[TEMPS_W-1:0];
				REG_PREHEAT_TEMP:     regs_q.preheat_temp     <= cfg.data[TEMP_W-1:0];
				REG_PREHEAT_DURATION: regs_q.preheat_duration <= cfg.data[MS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rps_checker.sv =====
// port-level checks on the reflow profile sequencer, bound to the top level
// depends on rps_pkg and reflow_profile_sequencer_macros.svh
`include "reflow_profile_sequencer_macros.svh"

module rps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_mode,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_relay_on,
	input logic [8:0] res_setpoint,
	input logic [1:0] res_phase,
	input logic [2:0] res_step_index,
	input logic       res_finished
);
	import rps_pkg::*;

	// a result waiting on the sink stays offered
	`RPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

	// an idle result carries no relay drive, setpoint or step
	`RPS_ASSERT_NOW(a_idle_zero, res_valid && (res_phase == PH_IDLE), !res_relay_on && (res_setpoint == '0) && (res_step_index == '0))

	// a run that ends on its own is reported from idle
	`RPS_ASSERT_NOW(a_fin_idle, res_valid && res_finished, res_phase == PH_IDLE)

	// nonzero step only during reflow
	`RPS_ASSERT_NOW(a_step_reflow, res_valid && (res_step_index != '0), res_phase == PH_REFLOW)

	// a stop item yields an idle, unfinished result on the next cycle
	`RPS_ASSERT_NEXT(a_stop_idle, cmd_valid && cmd_ready && (cmd_mode == MODE_STOP), res_valid && (res_phase == PH_IDLE) && !res_finished)

endmodule

bind reflow_profile_sequencer rps_checker u_rps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_mode      (cmd.mode),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_relay_on  (result.relay_on),
	.res_setpoint  (result.setpoint),
	.res_phase     (result.phase),
	.res_step_index(result.step_index),
	.res_finished  (result.finished)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for reflow_profile_sequencer: directed and random command items, with each
// status item checked against an in-bench model of the oven sequencer
// depends on rps_pkg and the rps_cmd_if, rps_result_if and rps_cfg_if channel interfaces
module tb;
	import rps_pkg::*;

	localparam int STEPS        = 6;
	localparam int REG_COUNT    = 5;
	localparam int RANDOM_ITEMS = 100;

	typedef struct {
		logic              relay_on;
		logic [TEMP_W-1:0] setpoint;
		logic [1:0]        phase;
		logic [STEP_W-1:0] step_index;
		logic              finished;
	} oven_status_t;

	class oven_scoreboard;
		logic [WIN_W-1:0]   window_length;
		logic [TIMES_W-1:0] profile_times;
		logic [TEMPS_W-1:0] profile_temps;
		logic [TEMP_W-1:0]  preheat_temp;
		logic [MS_W-1:0]    preheat_duration;

		phase_t             run_phase;
		logic [MS_W-1:0]    elapsed_ms;
		logic [MSEC_W-1:0]  ms_in_second;
		logic [SEC_W-1:0]   elapsed_sec;
		logic [WIN_W-1:0]   window_position;
		logic [STEP_W-1:0]  step;

		oven_status_t       pending_status[$];
		int                 errors;
		int                 checked;
		int                 self_ended;

		function new();
			window_length    = WINDOW_RST;
			profile_times    = '0;
			profile_temps    = '0;
			preheat_temp     = PREHEAT_T_RST;
			preheat_duration = PREHEAT_D_RST;
			clear_run(PH_IDLE);
			errors     = 0;
			checked    = 0;
			self_ended = 0;
		endfunction

		function void clear_run(phase_t ph);
			run_phase       = ph;
			elapsed_ms      = '0;
			ms_in_second    = '0;
			elapsed_sec     = '0;
			window_position = '0;
			step            = '0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WINDOW_LENGTH:    window_length    = data[WIN_W-1:0];
				REG_PROFILE_TIMES:    profile_times    = data[TIMES_W-1:0];
				REG_PROFILE_TEMPS:    profile_temps    = data[TEMPS_W-1:0];
				REG_PREHEAT_TEMP:     preheat_temp     = data[TEMP_W-1:0];
				REG_PREHEAT_DURATION: preheat_duration = data[MS_W-1:0];
				default: ;
			endcase
		endfunction

		// steps past the six packed fields read as zero
		function logic [TIME_W-1:0] end_time(logic [STEP_W-1:0] s);
			if (int'(s) >= REG_STEPS) begin
				return '0;
			end
			return TIME_W'(profile_times >> (TIME_W * int'(s)));
		endfunction

		function logic [TEMP_W-1:0] step_setpoint(logic [STEP_W-1:0] s);
			if (int'(s) >= REG_STEPS) begin
				return '0;
			end
			return TEMP_W'(profile_temps >> (TEMP_W * int'(s)));
		endfunction

		function void note_command(mode_t mode, logic [WIN_W-1:0] drive);
			oven_status_t     st;
			logic [WIN_W:0]   next_pos;
			logic             fin;
			fin = 1'b0;
			case (mode)
				MODE_PREHEAT: clear_run(PH_PREHEAT);
				MODE_REFLOW:  clear_run(PH_REFLOW);
				MODE_STOP:    clear_run(PH_IDLE);
				default: begin
					if (run_phase == PH_IDLE) begin
						step = '0;
					end else begin
						if (elapsed_ms != MS_MAX) elapsed_ms++;
						if (ms_in_second >= MSEC_LAST) begin
							ms_in_second = '0;
							if (elapsed_sec != SEC_MAX) elapsed_sec++;
						end else begin
							ms_in_second++;
						end
						next_pos = {1'b0, window_position} + (WIN_W+1)'(1);
						if (next_pos >= {1'b0, window_length}) next_pos = '0;
						window_position = next_pos[WIN_W-1:0];
						if (run_phase == PH_PREHEAT) begin
							if (elapsed_ms > preheat_duration) begin
								run_phase = PH_IDLE;
								step      = '0;
								fin       = 1'b1;
							end
						end else if (run_phase == PH_REFLOW) begin
							// at most one step per tick
							if (elapsed_sec > {1'b0, end_time(step)}) begin
								if (step >= STEP_W'(STEPS - 1)) begin
									run_phase = PH_IDLE;
									step      = '0;
									fin       = 1'b1;
								end else begin
									step++;
								end
							end
						end else begin
							run_phase = PH_IDLE;
							step      = '0;
						end
					end
				end
			endcase

			st.finished = fin;
			case (run_phase)
				PH_PREHEAT: begin
					st.relay_on   = (drive >= window_position);
					st.setpoint   = preheat_temp;
					st.phase      = PH_PREHEAT;
					st.step_index = '0;
				end
				PH_REFLOW: begin
					st.relay_on   = (drive >= window_position);
					st.setpoint   = step_setpoint(step);
					st.phase      = PH_REFLOW;
					st.step_index = step;
				end
				default: begin
					st.relay_on   = 1'b0;
					st.setpoint   = '0;
					st.phase      = PH_IDLE;
					st.step_index = '0;
				end
			endcase
			pending_status.push_back(st);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_status(oven_status_t got);
			oven_status_t want;
			if (pending_status.size() == 0) begin
				errors++;
				$display("%0t: status item with none expected, expected nothing, actual phase %0d",
					$time, got.phase);
				return;
			end
			want = pending_status.pop_front();
			checked++;
			if (want.finished) self_ended++;
			compare_field("relay_on", 16'(want.relay_on), 16'(got.relay_on));
			compare_field("setpoint", 16'(want.setpoint), 16'(got.setpoint));
			compare_field("phase", 16'(want.phase), 16'(got.phase));
			compare_field("step_index", 16'(want.step_index), 16'(got.step_index));
			compare_field("finished", 16'(want.finished), 16'(got.finished));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rps_cmd_if    cmd_ch();
	rps_result_if res_ch();
	rps_cfg_if    cfg_ch();

	reflow_profile_sequencer #(
		.PROFILE_STEPS(STEPS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	oven_scoreboard oven_sb;
	bit cmd_gaps;
	bit res_stalls;
	int items_sent;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stall bursts while res_stalls is set
	initial begin
		int stall;
		stall = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else if (res_stalls && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 7) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		oven_status_t got;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.relay_on   = res_ch.relay_on;
			got.setpoint   = res_ch.setpoint;
			got.phase      = res_ch.phase;
			got.step_index = res_ch.step_index;
			got.finished   = res_ch.finished;
			oven_sb.check_status(got);
		end
	end

	function automatic logic [WIN_W-1:0] random_drive();
		case ($urandom_range(0, 4))
			0, 1:    return WIN_W'($urandom);
			2:       return WIN_W'($urandom_range(0, oven_sb.window_length));
			3:       return WIN_W'($urandom_range(0, 12));
			default: return ($urandom_range(0, 1) != 0) ? {WIN_W{1'b1}} : {WIN_W{1'b0}};
		endcase
	endfunction

	task automatic send_command(mode_t mode, logic [WIN_W-1:0] drive);
		int gap;
		if (cmd_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode  <= mode;
		cmd_ch.drive <= drive;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		oven_sb.note_command(mode, drive);
		items_sent++;
	endtask

	// every item returns one status item, so an empty queue means the block is idle
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (oven_sb.pending_status.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		oven_sb.write_register(idx, data);
	endtask

	function automatic logic [TIMES_W-1:0] random_times(int max_field);
		logic [TIMES_W-1:0] times;
		for (int i = 0; i < REG_STEPS; i++) begin
			times[i*TIME_W +: TIME_W] = TIME_W'($urandom_range(0, max_field));
		end
		return times;
	endfunction

	task automatic random_config(bit all);
		if (all || $urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 5))
				0:       write_reg(REG_WINDOW_LENGTH, '0);
				1:       write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(1));
				2:       write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'({WIN_W{1'b1}}));
				3:       write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'($urandom_range(1, 4095)));
				default: write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'($urandom_range(2, 8)));
			endcase
		end
		if (all || $urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 4))
				0:       write_reg(REG_PROFILE_TIMES, CFG_DATA_W'({$urandom, $urandom}));
				1:       write_reg(REG_PROFILE_TIMES, {CFG_DATA_W{1'b1}});
				default: write_reg(REG_PROFILE_TIMES, CFG_DATA_W'(random_times(1)));
			endcase
		end
		if (all || $urandom_range(0, 1) != 0) begin
			write_reg(REG_PROFILE_TEMPS, CFG_DATA_W'({$urandom, $urandom}));
		end
		if (all || $urandom_range(0, 1) != 0) begin
			write_reg(REG_PREHEAT_TEMP, CFG_DATA_W'($urandom));
		end
		if (all || $urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 5))
				0:       write_reg(REG_PREHEAT_DURATION, CFG_DATA_W'($urandom));
				1:       write_reg(REG_PREHEAT_DURATION, CFG_DATA_W'(MS_MAX));
				default: write_reg(REG_PREHEAT_DURATION, CFG_DATA_W'($urandom_range(0, 40)));
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_sequence();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// noise: any mode, any drive
			n = $urandom_range(1, 4);
			repeat (n) send_command(mode_t'($urandom_range(0, 3)), random_drive());
		end else if (kind <= 4) begin
			send_command(MODE_PREHEAT, random_drive());
			if (oven_sb.preheat_duration < 60) begin
				n = int'(oven_sb.preheat_duration) + $urandom_range(0, 4);
			end else begin
				n = $urandom_range(0, 60);
			end
			repeat (n) send_command(MODE_TICK, random_drive());
			if ($urandom_range(0, 2) == 0) send_command(MODE_STOP, random_drive());
		end else if (kind <= 8) begin
			send_command(MODE_REFLOW, random_drive());
			n = $urandom_range(0, 60);
			repeat (n) send_command(MODE_TICK, random_drive());
			if ($urandom_range(0, 1) == 0) send_command(MODE_STOP, random_drive());
		end else begin
			// broken run: restart or stop shortly after a start
			send_command(mode_t'($urandom_range(1, 2)), random_drive());
			n = $urandom_range(0, 3);
			repeat (n) send_command(MODE_TICK, random_drive());
			send_command(mode_t'($urandom_range(1, 3)), random_drive());
		end
	endtask

	initial begin
		int target;
		bit first;
		oven_sb      = new();
		items_sent   = 0;
		cmd_gaps     = 1'b0;
		res_stalls   = 1'b0;
		arst_n       <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.mode  <= MODE_TICK;
		cmd_ch.drive <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register reset values
		send_command(MODE_TICK, {WIN_W{1'b1}});
		send_command(MODE_PREHEAT, '0);
		send_command(MODE_TICK, '0);
		send_command(MODE_TICK, {WIN_W{1'b1}});
		send_command(MODE_STOP, {WIN_W{1'b1}});
		drain();

		// all-ones registers; writes to unused indexes must not land anywhere
		write_reg(REG_WINDOW_LENGTH, {CFG_DATA_W{1'b1}});
		write_reg(REG_PROFILE_TIMES, {CFG_DATA_W{1'b1}});
		write_reg(REG_PROFILE_TEMPS, {CFG_DATA_W{1'b1}});
		write_reg(REG_PREHEAT_TEMP, {CFG_DATA_W{1'b1}});
		write_reg(REG_PREHEAT_DURATION, {CFG_DATA_W{1'b1}});
		for (int k = REG_COUNT; k < 2 ** CFG_IDX_W; k++) begin
			write_reg(CFG_IDX_W'(k), '0);
		end
		cfg_ch.valid <= 1'b0;
		send_command(MODE_REFLOW, {WIN_W{1'b1}});
		send_command(MODE_TICK, WIN_W'(1));
		send_command(MODE_PREHEAT, {WIN_W{1'b1}});
		send_command(MODE_TICK, '0);
		send_command(MODE_REFLOW, '0);
		send_command(MODE_STOP, '0);
		drain();

		// zero window holds the position, zero duration ends preheat on the first tick
		write_reg(REG_WINDOW_LENGTH, '0);
		write_reg(REG_PREHEAT_DURATION, '0);
		write_reg(REG_PREHEAT_TEMP, '0);
		write_reg(REG_PROFILE_TIMES, '0);
		cfg_ch.valid <= 1'b0;
		send_command(MODE_PREHEAT, '0);
		send_command(MODE_TICK, '0);
		send_command(MODE_TICK, WIN_W'($urandom));
		drain();

		write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(1));
		write_reg(REG_PREHEAT_DURATION, CFG_DATA_W'(1));
		cfg_ch.valid <= 1'b0;
		send_command(MODE_PREHEAT, '0);
		send_command(MODE_TICK, '0);
		send_command(MODE_TICK, '0);
		send_command(MODE_REFLOW, '0);
		send_command(MODE_TICK, WIN_W'($urandom));
		send_command(MODE_STOP, '0);
		send_command(MODE_STOP, WIN_W'($urandom));

		// random phases, each with its own settings and idling
		target = items_sent + RANDOM_ITEMS;
		first  = 1'b1;
		while (items_sent < target) begin
			drain();
			random_config(first);
			first      = 1'b0;
			cmd_gaps   = ($urandom_range(0, 3) != 0);
			res_stalls = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 8)) run_sequence();
		end

		// one full reflow profile with no idling
		drain();
		cmd_gaps   = 1'b0;
		res_stalls = 1'b0;
		write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(7));
		write_reg(REG_PROFILE_TIMES, '0);
		write_reg(REG_PROFILE_TEMPS, CFG_DATA_W'({$urandom, $urandom}));
		cfg_ch.valid <= 1'b0;
		send_command(MODE_REFLOW, random_drive());
		while (oven_sb.run_phase != PH_IDLE) send_command(MODE_TICK, random_drive());
		repeat (3) send_command(MODE_TICK, random_drive());

		drain();
		repeat (4) @(posedge clk);
		$display("%0d command items sent, %0d status items checked", items_sent, oven_sb.checked);
		$display("%0d runs ended on their own across preheat, reflow and register settings",
			oven_sb.self_ended);
		if (oven_sb.errors == 0 && oven_sb.pending_status.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
